// ----- hdl/arpr_pkg.sv -----
// Shared types, constants and the reply program for the ARP request responder.
// Used by the top level, arpr_rx and arpr_seq; depends on nothing else.
package arpr_pkg;

    // Captured header length and its address width.
    localparam int HDR_BYTES = 42;
    localparam int HDR_AW    = 6;

    // One program step per reply byte.
    localparam int STEP_W = 6;

    // Fixed bytes checked in the request and written into the reply.
    localparam logic [7:0] ETYPE_HI  = 8'h08;
    localparam logic [7:0] ETYPE_LO  = 8'h06;
    localparam logic [7:0] OPER_HI   = 8'h00;
    localparam logic [7:0] OPER_REQ  = 8'h01;
    localparam logic [7:0] OPER_REP  = 8'h02;

    // Header offsets of the bytes checked during capture.
    localparam int OFS_ETYPE_HI = 12;
    localparam int OFS_ETYPE_LO = 13;
    localparam int OFS_OPER_HI  = 20;
    localparam int OFS_OPER_LO  = 21;

    // Configuration register indexes.
    typedef enum logic
    {
        CFG_OWN_MAC = 1'b0,
        CFG_OWN_IP  = 1'b1
    } cfg_index_t;

    // Source of one reply byte.
    typedef enum logic [1:0]
    {
        SRC_HDR   = 2'd0,
        SRC_MAC   = 2'd1,
        SRC_IP    = 2'd2,
        SRC_CONST = 2'd3
    } src_t;

    // One control word: byte source, its argument, and the end-of-program mark.
    typedef struct packed
    {
        src_t       src;
        logic [7:0] arg;
        logic       last;
    } ctl_word_t;

    // Header store write request from the capture side.
    typedef struct packed
    {
        logic              en;
        logic [HDR_AW-1:0] addr;
        logic [7:0]        data;
    } hdr_wr_t;

    // Reply program ROM: one word per reply byte, in wire order.
    function automatic ctl_word_t ctl_rom(input logic [STEP_W-1:0] p);
        ctl_word_t  w;
        logic [7:0] p8;
        p8     = 8'(p);
        w.last = (p == STEP_W'(HDR_BYTES - 1));
        w.src  = SRC_CONST;
        w.arg  = 8'h00;
        priority if (p8 < 8'd6)
        begin
            // Destination: old Ethernet source.
            w.src = SRC_HDR;
            w.arg = p8 + 8'd6;
        end
        else if (p8 < 8'd12)
        begin
            w.src = SRC_MAC;
            w.arg = p8 - 8'd6;
        end
        else if (p8 == 8'd12)
        begin
            w.arg = ETYPE_HI;
        end
        else if (p8 == 8'd13)
        begin
            w.arg = ETYPE_LO;
        end
        else if (p8 < 8'd20)
        begin
            // Hardware type, protocol type and lengths are copied.
            w.src = SRC_HDR;
            w.arg = p8;
        end
        else if (p8 == 8'd20)
        begin
            w.arg = OPER_HI;
        end
        else if (p8 == 8'd21)
        begin
            w.arg = OPER_REP;
        end
        else if (p8 < 8'd28)
        begin
            w.src = SRC_MAC;
            w.arg = p8 - 8'd22;
        end
        else if (p8 < 8'd32)
        begin
            w.src = SRC_IP;
            w.arg = p8 - 8'd28;
        end
        else if (p8 < 8'd38)
        begin
            // Target MAC: old Ethernet source.
            w.src = SRC_HDR;
            w.arg = p8 - 8'd26;
        end
        else
        begin
            // Target IP: old ARP sender IP.
            w.src = SRC_HDR;
            w.arg = p8 - 8'd10;
        end
        return w;
    endfunction

endpackage

// ----- hdl/arp_request_responder.sv -----
// ARP request responder top level: configuration registers, header store,
// receive checker and reply sequencer. Depends on arpr_pkg, arpr_ram, arpr_rx, arpr_seq.
//
// Usage:
//   The slave stream (s_*) carries a received Ethernet frame, one byte per
//   word, with s_tlast on the final byte. The master stream (m_*) carries the
//   42-byte ARP reply, one byte per word, with m_tlast on the 42nd byte.
//   own_mac and own_ip are written through cfg_we/cfg_index/cfg_data; the user
//   writes them only while idle, which the block does not enforce. The receive
//   side takes one word per cycle while s_tready is high. When a frame that is an
//   ARP request of at least 42 bytes ends, s_tready drops while the reply program
//   runs: the sequencer issues one of its 42 steps per cycle unless the master
//   side stalls. The first reply word passes the step counter, the second stage
//   and the output word register; the rest follow at one word per cycle, set by
//   the header store read port, which serves one program step per cycle. A stall
//   on m_tready freezes the sequencer and holds the output word. Reset clears the
//   byte counter, the program state and both registers.
module arp_request_responder #(
    parameter int FRAME_MAX = 1500
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    // Received frame.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    // Reply frame.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast
);

    import arpr_pkg::*;

    logic [47:0]       own_mac_reg;
    logic [31:0]       own_ip_reg;
    logic              accept;
    hdr_wr_t           hdr_wr;
    logic              start;
    logic              active;
    logic              rd_en;
    logic [HDR_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OWN_MAC: own_mac_reg <= cfg_data;
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    // Input is held off while a reply program runs over the header store.
    assign s_tready = !active;
    assign accept   = s_tvalid && s_tready;

    arpr_rx #(
        .FRAME_MAX (FRAME_MAX)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .rx_last (s_tlast),
        .hdr_wr  (hdr_wr),
        .start   (start)
    );

    arpr_ram #(
        .WIDTH (8),
        .DEPTH (HDR_BYTES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_wr.en),
        .wr_addr (hdr_wr.addr),
        .wr_data (hdr_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    arpr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .own_mac  (own_mac_reg),
        .own_ip   (own_ip_reg),
        .active   (active),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/arpr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the captured frame header.
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/arpr_rx.sv -----
// Receive side: counts frame bytes, stores the first 42 and checks for an ARP request.
// Depends on arpr_pkg.
module arpr_rx #(
    parameter int FRAME_MAX = 1500
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             rx_last,
    output arpr_pkg::hdr_wr_t hdr_wr,
    output logic             start
);

    import arpr_pkg::*;

    localparam int CW = $clog2(FRAME_MAX + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [3:0]    match_reg;
    logic [3:0]    match_next;
    logic          counting;
    logic          enough;

    assign counting = (count_reg < CW'(FRAME_MAX));

    // Once the count reaches 41 the current byte makes the frame long enough;
    // a saturated count is always past the header.
    assign enough = (count_reg >= CW'(HDR_BYTES - 1));

    // Header store write for the first 42 bytes.
    always_comb
    begin
        hdr_wr.en   = accept && counting && (count_reg < CW'(HDR_BYTES));
        hdr_wr.addr = count_reg[HDR_AW-1:0];
        hdr_wr.data = rx_byte;
    end

    // Request detected at the last byte of the frame.
    assign start = accept && rx_last && enough && (&match_reg);

    // Byte counter and field match flags.
    always_comb
    begin
        count_next = count_reg;
        match_next = match_reg;
        if (accept)
        begin
            if (counting)
            begin
                count_next = count_reg + CW'(1);
                if ((count_reg == CW'(OFS_ETYPE_HI)) && (rx_byte == ETYPE_HI))
                begin
                    match_next[0] = 1'b1;
                end
                if ((count_reg == CW'(OFS_ETYPE_LO)) && (rx_byte == ETYPE_LO))
                begin
                    match_next[1] = 1'b1;
                end
                if ((count_reg == CW'(OFS_OPER_HI)) && (rx_byte == OPER_HI))
                begin
                    match_next[2] = 1'b1;
                end
                if ((count_reg == CW'(OFS_OPER_LO)) && (rx_byte == OPER_REQ))
                begin
                    match_next[3] = 1'b1;
                end
            end
            if (rx_last)
            begin
                count_next = '0;
                match_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            match_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

endmodule

// ----- hdl/arpr_seq.sv -----
// Reply sequencer: steps through the program ROM, reads the header store and
// drives the output word register. Depends on arpr_pkg.
module arpr_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [47:0]                 own_mac,
    input  logic [31:0]                 own_ip,
    output logic                        active,
    output logic                        rd_en,
    output logic [arpr_pkg::HDR_AW-1:0] rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);

    import arpr_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              active_reg;
    logic              active_next;
    ctl_word_t         ctl;

    logic              s2_valid_reg;
    ctl_word_t         s2_ctl_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              advance;
    logic [7:0]        sel_byte;

    // The whole pipeline moves together when the output word can be replaced.
    assign advance = !out_valid_reg || m_tready;
    assign ctl     = ctl_rom(pc_reg);
    assign active  = active_reg;
    assign rd_en   = advance;
    assign rd_addr = ctl.arg[HDR_AW-1:0];

    // Step counter and program run flag.
    always_comb
    begin
        pc_next     = pc_reg;
        active_next = active_reg;
        if (start)
        begin
            pc_next     = '0;
            active_next = 1'b1;
        end
        else if (active_reg && advance)
        begin
            if (ctl.last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            active_reg <= active_next;
        end
    end

    // Second stage: control word aligned with the header read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_ctl_reg <= ctl;
        end
    end

    // Byte select from the source named in the control word.
    always_comb
    begin
        unique case (s2_ctl_reg.src)
            SRC_HDR:   sel_byte = rd_data;
            SRC_MAC:   sel_byte = own_mac[(5 - int'(s2_ctl_reg.arg[2:0])) * 8 +: 8];
            SRC_IP:    sel_byte = own_ip[(3 - int'(s2_ctl_reg.arg[1:0])) * 8 +: 8];
            SRC_CONST: sel_byte = s2_ctl_reg.arg;
            default:   sel_byte = s2_ctl_reg.arg;
        endcase
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= s2_ctl_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule
